// ===== rtl/alt_pkg.sv =====
// Shared types for the allocation lease table: command and status codes,
// and the lease entry record carried along the cell chain. No dependencies.
`default_nettype none
package alt_pkg;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        STS_TRACKED    = 3'd0,
        STS_UNTRACKED  = 3'd1,
        STS_ALLOC_FAIL = 3'd2,
        STS_FREED      = 3'd3,
        STS_EXPIRED    = 3'd4,
        STS_TICK_DONE  = 3'd5,
        STS_NULL       = 3'd6
    } t_status;

    typedef struct packed {
        logic [31:0] address;
        logic [31:0] size;
        logic [31:0] start;
        logic [31:0] keep;
    } t_entry;

endpackage
`default_nettype wire

// ===== rtl/alt_cell.sv =====
// One lease entry of the ring; loads its neighbor's entry on each shift.
// Depends on alt_pkg.
`default_nettype none
module alt_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_shift,
    input  wire alt_pkg::t_entry i_entry,
    output alt_pkg::t_entry      o_entry
);
    import alt_pkg::*;

    t_entry r_entry;

    // Clear at reset: a zero size marks the slot free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

// ===== rtl/allocation_lease_table.sv =====
// Top level of the allocation lease table: command sequencer, counters,
// output register and a ring of alt_cell lease entries. Depends on alt_pkg, alt_cell.
//
//   channel | direction | handshake               | words
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | i_in_valid / o_in_ready | one command word
//   out     | output    | o_out_valid / i_out_ready | 0 or 1 word, or up to SLOTS+1 on tick
//
// Sequence: an allocate or free with a nonzero address and every tick pass through
// accept, one ring rotation step per slot and finish; a null allocate or free goes
// from accept to finish, and command 3 is only accepted. All compares sit at the
// single head cell: the ring rotates one slot per cycle past it unless an expiry waits.
// Reset: synchronous, clears every cell and counter.
// Stalls: an expiring slot or the final word waits at the head while the output
// register is still held; a new command is taken only when the sequencer is idle.
`default_nettype none
module allocation_lease_table #(
    parameter int SLOTS    = 16,
    localparam int SLOT_W  = $clog2(SLOTS + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // command channel
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [1:0]          i_command,
    input  wire logic [31:0]         i_address,
    input  wire logic [31:0]         i_alloc_size,
    input  wire logic [31:0]         i_keep_time,
    // result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [2:0]               o_status,
    output logic [31:0]              o_release_address,
    output logic [SLOT_W-1:0]        o_slot,
    output logic [31:0]              o_fail_count,
    output logic [31:0]              o_alloc_total,
    output logic [31:0]              o_seconds_now,
    output logic                     o_last
);
    import alt_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] NO_SLOT  = SLOT_W'(SLOTS);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [31:0]        r_addr;
    logic [31:0]        r_size;
    logic [31:0]        r_keep;
    logic               r_found;
    logic [SLOT_W-1:0]  r_slot;
    logic [IDX_W-1:0]   r_idx;
    logic [31:0]        r_seconds;
    logic [31:0]        r_fails;
    logic [31:0]        r_total;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [31:0]        r_out_addr;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [31:0]        r_out_fails;
    logic [31:0]        r_out_total;
    logic [31:0]        r_out_seconds;
    logic               r_out_last;

    // Ring of cells: cell i takes cell i+1, the last cell takes the edited head.
    t_entry w_cell [SLOTS];
    t_entry n_head;
    t_entry w_head;
    logic   w_shift;

    assign w_head = w_cell[0];

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            alt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_entry ((g == SLOTS - 1) ? n_head : w_cell[(g + 1) % SLOTS]),
                .o_entry (w_cell[g])
            );
        end
    endgenerate

    // Head compares: the entry now in cell 0 is original slot r_idx.
    logic w_out_free;
    logic w_alloc_hit;
    logic w_free_hit;
    logic w_expire_hit;
    logic w_out_load;
    logic [31:0] w_due;

    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_due        = w_head.start + w_head.keep;
    assign w_alloc_hit  = (r_cmd == CMD_ALLOC) && !r_found && (w_head.size == '0);
    assign w_free_hit   = (r_cmd == CMD_FREE) && !r_found && (w_head.address == r_addr);
    assign w_expire_hit = (r_cmd == CMD_TICK) && (w_head.size != '0)
                          && (w_head.keep != '0) && (r_seconds >= w_due);
    // Hold the ring while an expiring entry waits for the output register.
    assign w_shift      = (r_state == S_SCAN) && (!w_expire_hit || w_out_free);
    // Load the output register with an expiry or with the final word.
    assign w_out_load   = (w_shift && w_expire_hit) || ((r_state == S_FIN) && w_out_free);

    always_comb begin
        n_head = w_head;
        if (w_alloc_hit) begin
            n_head.address = r_addr;
            n_head.size    = r_size;
            n_head.start   = r_seconds;
            n_head.keep    = r_keep;
        end else if (w_free_hit || w_expire_hit) begin
            n_head = '0;
        end
    end

    // Final word of the command, from the command and the scan outcome.
    t_status           w_fin_status;
    logic [31:0]       w_fin_addr;
    logic [SLOT_W-1:0] w_fin_slot;

    always_comb begin
        w_fin_status = STS_TICK_DONE;
        w_fin_addr   = '0;
        w_fin_slot   = NO_SLOT;
        unique case (r_cmd)
            CMD_ALLOC: begin
                if (r_addr == '0) begin
                    w_fin_status = STS_ALLOC_FAIL;
                end else if (r_found) begin
                    w_fin_status = STS_TRACKED;
                    w_fin_addr   = r_addr;
                    w_fin_slot   = r_slot;
                end else begin
                    w_fin_status = STS_UNTRACKED;
                    w_fin_addr   = r_addr;
                end
            end
            CMD_FREE: begin
                if (r_addr == '0) begin
                    w_fin_status = STS_NULL;
                end else begin
                    w_fin_status = STS_FREED;
                    w_fin_addr   = r_addr;
                    w_fin_slot   = r_slot;
                end
            end
            default: begin
                w_fin_status = STS_TICK_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_seconds   <= '0;
            r_fails     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Set valid on a load, drop the held word once taken.
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= t_cmd'(i_command);
                        r_addr  <= i_address;
                        r_size  <= i_alloc_size;
                        r_keep  <= i_keep_time;
                        r_found <= 1'b0;
                        r_slot  <= NO_SLOT;
                        r_idx   <= '0;
                        unique case (t_cmd'(i_command))
                            CMD_ALLOC: begin
                                r_total <= r_total + 32'd1;
                                if (i_address == '0) begin
                                    r_fails <= r_fails + 32'd1;
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            CMD_FREE: begin
                                r_state <= (i_address == '0) ? S_FIN : S_SCAN;
                            end
                            CMD_TICK: begin
                                r_seconds <= r_seconds + 32'd1;
                                r_state   <= S_SCAN;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_shift) begin
                        if (w_alloc_hit || w_free_hit) begin
                            r_found <= 1'b1;
                            r_slot  <= SLOT_W'(r_idx);
                        end
                        if (w_expire_hit) begin
                            r_out_status  <= STS_EXPIRED;
                            r_out_addr    <= w_head.address;
                            r_out_slot    <= SLOT_W'(r_idx);
                            r_out_fails   <= r_fails;
                            r_out_total   <= r_total;
                            r_out_seconds <= r_seconds;
                            r_out_last    <= 1'b0;
                        end
                        if (r_idx == LAST_IDX) begin
                            r_idx   <= '0;
                            r_state <= S_FIN;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_status  <= w_fin_status;
                        r_out_addr    <= w_fin_addr;
                        r_out_slot    <= w_fin_slot;
                        r_out_fails   <= r_fails;
                        r_out_total   <= r_total;
                        r_out_seconds <= r_seconds;
                        r_out_last    <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_release_address = r_out_addr;
    assign o_slot            = r_out_slot;
    assign o_fail_count      = r_out_fails;
    assign o_alloc_total     = r_out_total;
    assign o_seconds_now     = r_out_seconds;
    assign o_last            = r_out_last;

    // The ring must sit in its home position whenever no scan is running.
    a_idle_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SCAN) |-> (r_idx == '0))
        else $error("ring not at home position outside a scan");

    // Only expiry words are non-final.
    a_nonfinal_expired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_out_status == STS_EXPIRED))
        else $error("non-final word is not an expiry");

    // A failed allocation never names a slot.
    a_fail_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == STS_ALLOC_FAIL)) |-> (r_out_slot == NO_SLOT))
        else $error("failed allocation reports a slot");

    // Never shift the ring past an expiry that could not be loaded.
    a_expiry_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_shift && w_expire_hit) |-> w_out_free)
        else $error("expiry dropped while output register busy");

endmodule
`default_nettype wire

// ===== tb/allocation_lease_table_tb.sv =====
// Self-checking testbench for allocation_lease_table: a lease table mirror class
// predicts every result word, plain tasks drive the command channel and an always
// block drives result ready. Depends on alt_pkg and the allocation_lease_table RTL.
`timescale 1ns / 1ps

module allocation_lease_table_tb;
    import alt_pkg::*;

    localparam int SLOTS         = 16;
    localparam int SLOT_W        = $clog2(SLOTS + 1);
    localparam int RANDOM_ITEMS  = 305;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 2 * (SLOTS + 2);
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One result word as the block presents it on the output channel.
    typedef struct packed {
        t_status     status;
        logic [31:0] release_address;
        logic [4:0]  slot;
        logic [31:0] fail_count;
        logic [31:0] alloc_total;
        logic [31:0] seconds_now;
        logic        last;
    } t_lease_word;

    // Mirror of the lease table: replays each accepted command and queues the
    // words the block must answer with, then checks them in arrival order.
    class lease_table_mirror;
        logic [31:0] lease_address [SLOTS];
        logic [31:0] lease_size    [SLOTS];
        logic [31:0] lease_start   [SLOTS];
        logic [31:0] lease_keep    [SLOTS];
        logic [31:0] seconds;
        logic [31:0] failures;
        logic [31:0] attempts;
        t_lease_word words_due [$];
        int mismatches;
        int words_checked;
        int n_alloc, n_free, n_tick, n_expired, n_untracked, n_failed;

        function new();
            for (int i = 0; i < SLOTS; i++) clear_slot(i);
            seconds  = '0;
            failures = '0;
            attempts = '0;
        endfunction

        function void clear_slot(int i);
            lease_address[i] = '0;
            lease_size[i]    = '0;
            lease_start[i]   = '0;
            lease_keep[i]    = '0;
        endfunction

        function void emit(t_status st, logic [31:0] addr, int slot, logic fin);
            t_lease_word w;
            w.status          = st;
            w.release_address = addr;
            w.slot            = 5'(slot);
            w.fail_count      = failures;
            w.alloc_total     = attempts;
            w.seconds_now     = seconds;
            w.last            = fin;
            words_due.push_back(w);
        endfunction

        function void apply_command(logic [1:0] cmd, logic [31:0] addr,
                                    logic [31:0] size, logic [31:0] keep);
            int hit;
            logic [31:0] due;
            logic [31:0] gone;
            hit = SLOTS;
            case (cmd)
                CMD_ALLOC: begin
                    n_alloc++;
                    attempts++;
                    if (addr == '0) begin
                        failures++;
                        n_failed++;
                        emit(STS_ALLOC_FAIL, '0, SLOTS, 1'b1);
                    end else begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (lease_size[i] == '0) begin
                                hit = i;
                                break;
                            end
                        end
                        if (hit < SLOTS) begin
                            lease_start[hit]   = seconds;
                            lease_address[hit] = addr;
                            lease_size[hit]    = size;
                            lease_keep[hit]    = keep;
                            emit(STS_TRACKED, addr, hit, 1'b1);
                        end else begin
                            n_untracked++;
                            emit(STS_UNTRACKED, addr, SLOTS, 1'b1);
                        end
                    end
                end
                CMD_FREE: begin
                    n_free++;
                    if (addr == '0) begin
                        emit(STS_NULL, '0, SLOTS, 1'b1);
                    end else begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (lease_address[i] == addr) begin
                                hit = i;
                                break;
                            end
                        end
                        if (hit < SLOTS) clear_slot(hit);
                        emit(STS_FREED, addr, hit, 1'b1);
                    end
                end
                CMD_TICK: begin
                    n_tick++;
                    seconds++;
                    for (int i = 0; i < SLOTS; i++) begin
                        due = lease_start[i] + lease_keep[i];
                        if (lease_size[i] != '0 && lease_keep[i] != '0 && seconds >= due) begin
                            gone = lease_address[i];
                            clear_slot(i);
                            n_expired++;
                            emit(STS_EXPIRED, gone, i, 1'b0);
                        end
                    end
                    emit(STS_TICK_DONE, '0, SLOTS, 1'b1);
                end
                default: ;  // unused command: no state change, no words
            endcase
        endfunction

        function void compare_word(t_lease_word got);
            t_lease_word want;
            string diff;
            words_checked++;
            if (words_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] stray word: status %0d addr %h slot %0d last %0b",
                             $realtime, got.status, got.release_address, got.slot, got.last);
                return;
            end
            want = words_due.pop_front();
            diff = "";
            if (got.status          !== want.status)          diff = {diff, " status"};
            if (got.release_address !== want.release_address) diff = {diff, " release_address"};
            if (got.slot            !== want.slot)            diff = {diff, " slot"};
            if (got.fail_count      !== want.fail_count)      diff = {diff, " fail_count"};
            if (got.alloc_total     !== want.alloc_total)     diff = {diff, " alloc_total"};
            if (got.seconds_now     !== want.seconds_now)     diff = {diff, " seconds_now"};
            if (got.last            !== want.last)            diff = {diff, " last"};
            if (diff != "") begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] word mismatch on%s", $realtime, diff);
                    $display("    want: sts %0d addr %h slot %0d fail %0d tot %0d sec %0d last %0b",
                             want.status, want.release_address, want.slot, want.fail_count,
                             want.alloc_total, want.seconds_now, want.last);
                    $display("    got:  sts %0d addr %h slot %0d fail %0d tot %0d sec %0d last %0b",
                             got.status, got.release_address, got.slot, got.fail_count,
                             got.alloc_total, got.seconds_now, got.last);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block signals; every input holds a known value from time zero.
    // ------------------------------------------------------------------
    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_command    = '0;
    logic [31:0]       i_address    = '0;
    logic [31:0]       i_alloc_size = '0;
    logic [31:0]       i_keep_time  = '0;
    logic              o_out_valid;
    logic              i_out_ready  = 1'b0;
    logic [2:0]        o_status;
    logic [31:0]       o_release_address;
    logic [SLOT_W-1:0] o_slot;
    logic [31:0]       o_fail_count;
    logic [31:0]       o_alloc_total;
    logic [31:0]       o_seconds_now;
    logic              o_last;

    lease_table_mirror mirror = new();
    bit  calm;            // set to suppress idling on both channels
    int  commands_sent;   // accepted commands, ignored opcode excluded
    int  drain_pauses;
    int  quiet_cycles;

    allocation_lease_table #(.SLOTS(SLOTS)) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_command         (i_command),
        .i_address         (i_address),
        .i_alloc_size      (i_alloc_size),
        .i_keep_time       (i_keep_time),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_release_address (o_release_address),
        .o_slot            (o_slot),
        .o_fail_count      (o_fail_count),
        .o_alloc_total     (o_alloc_total),
        .o_seconds_now     (o_seconds_now),
        .o_last            (o_last)
    );

    // 4 ns clock: two ns high, two ns low.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side: check every accepted word, then pick ready for the next
    // cycle. Drop ready with a chance of about 9 in a hundred unless running calm.
    always @(posedge i_clk) begin
        t_lease_word got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.status          = t_status'(o_status);
            got.release_address = o_release_address;
            got.slot            = 5'(o_slot);
            got.fail_count      = o_fail_count;
            got.alloc_total     = o_alloc_total;
            got.seconds_now     = o_seconds_now;
            got.last            = o_last;
            mirror.compare_word(got);
        end
        i_out_ready <= calm || ($urandom_range(0, 99) >= 9);
    end

    // Watchdog: count cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles, %0d words still due",
                     $realtime, STALL_LIMIT, mirror.words_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Present one command word and hold it until accepted. Valid is lowered
    // only in the idle branch, so it never gets two updates in one step.
    task automatic send_word(input logic [1:0] cmd, input logic [31:0] addr,
                             input logic [31:0] size, input logic [31:0] keep);
        if (!calm && $urandom_range(0, 99) < 9) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_address    <= addr;
        i_alloc_size <= size;
        i_keep_time  <= keep;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        mirror.apply_command(cmd, addr, size, keep);
        if (cmd != CMD_UNUSED) commands_sent++;
    endtask

    // Stop sending and hold off until every predicted word has come back.
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        drain_pauses++;
        @(posedge i_clk);
        while (mirror.words_due.size() != 0) @(posedge i_clk);
    endtask

    // Allocator results: some failures, a small pool to force duplicates
    // and hits on free, the rest anywhere in the 32-bit space.
    function automatic logic [31:0] pick_alloc_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return '0;
        if (r < 55) return 32'($urandom_range(1, 40));
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return '0;
        if (r < 20) return '1;
        return $urandom();
    endfunction

    // Mostly short keeps so ticks expire leases; all-ones wraps the due time.
    function automatic logic [31:0] pick_keep();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return '0;
        if (r < 80) return 32'($urandom_range(1, 6));
        if (r < 90) return '1;
        return $urandom();
    endfunction

    // Prefer addresses that the table holds so frees hit live slots.
    function automatic logic [31:0] pick_free_address();
        int r;
        int base;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 70) begin
            base = $urandom_range(0, SLOTS - 1);
            for (int k = 0; k < SLOTS; k++)
                if (mirror.lease_address[(base + k) % SLOTS] != '0)
                    return mirror.lease_address[(base + k) % SLOTS];
        end
        if (r < 85) return 32'($urandom_range(1, 40));
        return $urandom();
    endfunction

    initial begin
        int start_count;
        int pick;
        int burst;

        // Hold reset, then release it once for the whole run.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: failure, null free, ignored opcode, unknown free.
        send_word(CMD_ALLOC, '0, '1, '1);
        send_word(CMD_FREE, '0, '1, '1);
        send_word(CMD_UNUSED, '1, '1, '1);
        send_word(CMD_FREE, 32'hFFFF_FFFF, '0, '0);
        // Zero-size lease: written but still free, and a free still finds it.
        send_word(CMD_ALLOC, 32'h0000_1000, '0, '0);
        send_word(CMD_FREE, 32'h0000_1000, '0, '0);
        // Zero-size lease overwritten by the next allocation.
        send_word(CMD_ALLOC, 32'h0000_2000, '0, 32'd5);
        send_word(CMD_ALLOC, 32'h0000_3000, '1, 32'd1);
        send_word(CMD_ALLOC, 32'hFFFF_FFFF, 32'd1, '0);
        send_word(CMD_ALLOC, 32'h0000_4000, 32'd16, '1);
        send_word(CMD_ALLOC, 32'h0000_5000, 32'd8, 32'd2);
        send_word(CMD_ALLOC, 32'h0000_3000, 32'd4, '0);
        send_word(CMD_TICK, '0, '0, '0);
        // Keep time that wraps the due sum: expires on the next tick.
        send_word(CMD_ALLOC, 32'h0000_6000, 32'd2, '1);
        send_word(CMD_TICK, '1, '1, '1);
        send_word(CMD_FREE, 32'h0000_3000, '0, '0);
        send_word(CMD_FREE, 32'h0000_3000, '0, '0);
        hold_until_drained();
        send_word(CMD_ALLOC, 32'hAAAA_AAAA, 32'h8000_0000, 32'h8000_0000);
        send_word(CMD_ALLOC, 32'h5555_5555, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(CMD_TICK, '0, '0, '0);
        send_word(CMD_TICK, '0, '0, '0);

        // Random part: bursts of well-formed traffic with random content,
        // some noise, and occasional full drains. Run calm in the middle.
        start_count = commands_sent;
        while (commands_sent - start_count < RANDOM_ITEMS) begin
            calm = (commands_sent - start_count >= 140) &&
                   (commands_sent - start_count < 220);
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                burst = $urandom_range(1, SLOTS + 2);
                repeat (burst) send_word(CMD_ALLOC, pick_alloc_address(), pick_size(),
                                         pick_keep());
            end else if (pick < 55) begin
                burst = $urandom_range(1, 6);
                repeat (burst) send_word(CMD_FREE, pick_free_address(), $urandom(),
                                         $urandom());
            end else if (pick < 85) begin
                burst = $urandom_range(1, 4);
                repeat (burst) send_word(CMD_TICK, $urandom(), $urandom(), $urandom());
            end else if (pick < 94) begin
                send_word(($urandom_range(0, 1) != 0) ? CMD_UNUSED : CMD_FREE, '0,
                          $urandom(), $urandom());
            end else begin
                hold_until_drained();
            end
        end
        calm = 1'b0;

        // Close the input, wait for the last words, then let the block settle.
        i_in_valid <= 1'b0;
        while (mirror.words_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d commands: %0d allocate (%0d failed, %0d table full), %0d free, %0d tick",
                 commands_sent, mirror.n_alloc, mirror.n_failed, mirror.n_untracked,
                 mirror.n_free, mirror.n_tick);
        $display("Checked %0d result words, %0d expiries, %0d drain pauses, %0d mismatches",
                 mirror.words_checked, mirror.n_expired, drain_pauses, mirror.mismatches);
        if (mirror.mismatches == 0 && mirror.words_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/alt_pkg.sv
rtl/alt_cell.sv
rtl/allocation_lease_table.sv
tb/allocation_lease_table_tb.sv
